/* src/gdad_pkg.sv */
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar functions for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package gdad_pkg;

  localparam int unsigned DayFieldW   = 5;
  localparam int unsigned MonthFieldW = 4;
  localparam int unsigned YearFieldW  = 12;
  localparam int unsigned SpanFieldW  = 12;
  localparam int unsigned CycleW      = 9;

  localparam logic [MonthFieldW-1:0] MonthJan = 4'd1;
  localparam logic [MonthFieldW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthFieldW-1:0] MonthDec = 4'd12;

  localparam logic [CycleW-1:0] CycleLast = 9'd399;

  localparam logic [DayFieldW-1:0] LeapFebLen = 5'd29;

  localparam logic [DayFieldW-1:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } gdad_cmd_t;

  typedef struct packed {
    logic more;
  } gdad_sts_t;

  // Position of the year within the 400-year Gregorian cycle.
  function automatic logic [CycleW-1:0] year_mod400(input logic [YearFieldW-1:0] year);
    logic [YearFieldW-1:0] r;
    r = year;
    if (r >= 12'd3200) r = r - 12'd3200;
    if (r >= 12'd1600) r = r - 12'd1600;
    if (r >= 12'd800)  r = r - 12'd800;
    if (r >= 12'd400)  r = r - 12'd400;
    return r[CycleW-1:0];
  endfunction

  function automatic logic is_leap(input logic [CycleW-1:0] cyc);
    return (cyc[1:0] == 2'b00) && (cyc != 9'd100) && (cyc != 9'd200) && (cyc != 9'd300);
  endfunction

  function automatic logic [DayFieldW-1:0] days_in(input logic [MonthFieldW-1:0] month,
                                                   input logic [CycleW-1:0] cyc);
    logic [MonthFieldW-1:0] idx;
    idx = month - MonthJan;
    if ((month == MonthFeb) && is_leap(cyc)) begin
      return LeapFebLen;
    end
    return (idx < 4'd12) ? MonthLen[idx] : MonthLen[0];
  endfunction

endpackage

`default_nettype wire

/* src/gdad_ctrl.sv */
// ----------------------------------------------------------------------------
// gdad_ctrl
// Controller: sequences load, month stepping and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  gdad_pkg::gdad_sts_t sts_i,
  output gdad_pkg::gdad_cmd_t cmd_o
);
  import gdad_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o.load = in_valid_i && (state_q == StIdle);
    cmd_o.step = (state_q == StRun) && sts_i.more;
    cmd_o.emit = (state_q == StRun) && !sts_i.more && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (!sts_i.more && out_free) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/gdad_datapath.sv */
// ----------------------------------------------------------------------------
// gdad_datapath
// Datapath: day accumulator, month and year counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_datapath #(
  parameter int unsigned MAX_INTERVAL = 3650
) (
  input  logic                                clk_i,
  input  gdad_pkg::gdad_cmd_t                 cmd_i,
  output gdad_pkg::gdad_sts_t                 sts_o,
  input  logic [gdad_pkg::DayFieldW-1:0]      start_day_i,
  input  logic [gdad_pkg::MonthFieldW-1:0]    start_month_i,
  input  logic [gdad_pkg::YearFieldW-1:0]     start_year_i,
  input  logic [gdad_pkg::SpanFieldW-1:0]     interval_days_i,
  output logic [gdad_pkg::DayFieldW-1:0]      next_day_o,
  output logic [gdad_pkg::MonthFieldW-1:0]    next_month_o,
  output logic [gdad_pkg::YearFieldW-1:0]     next_year_o
);
  import gdad_pkg::*;

  localparam int unsigned DayW  = $clog2(MAX_INTERVAL + 32);
  localparam int unsigned YearW = $clog2(4096 + MAX_INTERVAL / 365 + 2);

  logic [DayW-1:0]        day_q, day_d;
  logic [MonthFieldW-1:0] month_q, month_d;
  logic [YearW-1:0]       year_q, year_d;
  logic [CycleW-1:0]      cyc_q, cyc_d;

  logic [DayFieldW-1:0]   next_day_q;
  logic [MonthFieldW-1:0] next_month_q;
  logic [YearFieldW-1:0]  next_year_q;

  logic [31:0]            span_wide;
  logic [DayW-1:0]        span;
  logic [DayW-1:0]        cur_len;
  logic [MonthFieldW-1:0] start_month;

  assign span_wide = {{(32 - SpanFieldW){1'b0}}, interval_days_i};
  assign span      = (span_wide > 32'(MAX_INTERVAL)) ? DayW'(MAX_INTERVAL)
                                                     : span_wide[DayW-1:0];

  assign start_month = ((start_month_i < MonthJan) || (start_month_i > MonthDec))
                       ? MonthJan : start_month_i;

  assign cur_len    = {{(DayW - DayFieldW){1'b0}}, days_in(month_q, cyc_q)};
  assign sts_o.more = (day_q > cur_len);

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    cyc_d   = cyc_q;
    if (cmd_i.load) begin
      day_d   = {{(DayW - DayFieldW){1'b0}}, start_day_i} + span;
      month_d = start_month;
      year_d  = {{(YearW - YearFieldW){1'b0}}, start_year_i};
      cyc_d   = year_mod400(start_year_i);
    end else if (cmd_i.step) begin
      day_d = day_q - cur_len;
      if (month_q == MonthDec) begin
        month_d = MonthJan;
        year_d  = year_q + YearW'(1);
        cyc_d   = (cyc_q == CycleLast) ? '0 : cyc_q + CycleW'(1);
      end else begin
        month_d = month_q + MonthFieldW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    cyc_q   <= cyc_d;
    if (cmd_i.emit) begin
      next_day_q   <= day_q[DayFieldW-1:0];
      next_month_q <= month_q;
      next_year_q  <= year_q[YearFieldW-1:0];
    end
  end

  assign next_day_o   = next_day_q;
  assign next_month_o = next_month_q;
  assign next_year_o  = next_year_q;

endmodule

`default_nettype wire

/* src/gregorian_date_add_days_unit.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds an interval in days to a Gregorian date.
// ----------------------------------------------------------------------------
// A request carries a start date and an interval on a valid/ready input
// channel. The interval is saturated to MAX_INTERVAL, added to the day, and
// then one whole month is subtracted per clock cycle by the datapath until
// the day fits its month. The resulting date leaves on a valid/ready output
// channel with a registered payload.
// The time from acceptance to output valid grows with the number of
// month boundaries crossed (about 121 for an interval of 3650 days), as
// the month-stepping loop sets it; one request is in work at a time, and
// the next is accepted once the result is registered.
// While the receiver stalls, the result stays in the output register and a
// new request is still accepted and worked on; it waits at the end of its
// loop until the output register frees up. Reset clears the controller and
// the output valid flag; the block is ready for a request right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_add_days_unit #(
  parameter int unsigned MAX_INTERVAL = 3650
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gdad_pkg::DayFieldW-1:0]   start_day_i,
  input  logic [gdad_pkg::MonthFieldW-1:0] start_month_i,
  input  logic [gdad_pkg::YearFieldW-1:0]  start_year_i,
  input  logic [gdad_pkg::SpanFieldW-1:0]  interval_days_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gdad_pkg::DayFieldW-1:0]   next_day_o,
  output logic [gdad_pkg::MonthFieldW-1:0] next_month_o,
  output logic [gdad_pkg::YearFieldW-1:0]  next_year_o
);
  import gdad_pkg::*;

  gdad_cmd_t cmd;
  gdad_sts_t sts;

  gdad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdad_datapath #(
    .MAX_INTERVAL (MAX_INTERVAL)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_day_i     (start_day_i),
    .start_month_i   (start_month_i),
    .start_year_i    (start_year_i),
    .interval_days_i (interval_days_i),
    .next_day_o      (next_day_o),
    .next_month_o    (next_month_o),
    .next_year_o     (next_year_o)
  );

endmodule

`default_nettype wire

/* src/gdad_checker.sv */
// ----------------------------------------------------------------------------
// gdad_checker
// Port-level checks for the date adder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gdad_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [gdad_pkg::DayFieldW-1:0]   start_day_i,
  input logic [gdad_pkg::MonthFieldW-1:0] start_month_i,
  input logic [gdad_pkg::YearFieldW-1:0]  start_year_i,
  input logic [gdad_pkg::SpanFieldW-1:0]  interval_days_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [gdad_pkg::DayFieldW-1:0]   next_day_o,
  input logic [gdad_pkg::MonthFieldW-1:0] next_month_o,
  input logic [gdad_pkg::YearFieldW-1:0]  next_year_o
);
  import gdad_pkg::*;

  // A stalled result keeps its valid and its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_day_o)
      && $stable(next_month_o) && $stable(next_year_o))
    else $error("stalled result changed");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

  // A new result frees the block for the next request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("block busy after delivering a result");

  // Every result carries a real month.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_month_o >= MonthJan) && (next_month_o <= MonthDec))
    else $error("result month out of range");

endmodule

bind gregorian_date_add_days_unit gdad_checker u_gdad_checker (.*);

`default_nettype wire
